// ===== hw/rtl/delm_pkg.sv =====
// Shared constants, types and helpers of the decayed event level monitor.
// Used by every module in hw/rtl; depends on nothing.
`default_nettype none

package delm_pkg;

  localparam int EVENT_DEPTH = 256;
  localparam int TIME_BITS   = 48;

  localparam int ADDR_W = $clog2(EVENT_DEPTH);
  localparam int CNT_W  = $clog2(EVENT_DEPTH + 1);

  localparam int WIN_W  = 24;
  localparam int HOLD_W = 24;
  localparam int THR_W  = 16;
  localparam int SEV_W  = 2;
  localparam int LVL_W  = 2;
  localparam int WGT_W  = 7;

  localparam int PROD_W = WGT_W + WIN_W;
  localparam int SUM_W  = PROD_W + CNT_W;
  localparam int THRP_W = THR_W + WIN_W;
  localparam int CMP_W  = (SUM_W > THRP_W) ? SUM_W : THRP_W;

  // configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 24;
  localparam logic [CFG_ADDR_W-1:0] REG_WINDOW   = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_PROMOTE  = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_DEMOTE   = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_CRIT_THR = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_HIGH_THR = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_MED_THR  = 3'd5;

  localparam logic [WIN_W-1:0]  WINDOW_RST   = 24'd900000;
  localparam logic [HOLD_W-1:0] PROMOTE_RST  = 24'd10000;
  localparam logic [HOLD_W-1:0] DEMOTE_RST   = 24'd60000;
  localparam logic [THR_W-1:0]  CRIT_THR_RST = 16'd100;
  localparam logic [THR_W-1:0]  HIGH_THR_RST = 16'd40;
  localparam logic [THR_W-1:0]  MED_THR_RST  = 16'd10;

  // input item kinds
  localparam logic FUNC_STORE = 1'b0;
  localparam logic FUNC_TICK  = 1'b1;

  // severity and level codes
  localparam logic [SEV_W-1:0] SEV_LOW    = 2'd0;
  localparam logic [SEV_W-1:0] SEV_MEDIUM = 2'd1;
  localparam logic [SEV_W-1:0] SEV_HIGH   = 2'd2;
  localparam logic [SEV_W-1:0] SEV_CRIT   = 2'd3;

  localparam logic [LVL_W-1:0] LVL_LOW    = 2'd0;
  localparam logic [LVL_W-1:0] LVL_MEDIUM = 2'd1;
  localparam logic [LVL_W-1:0] LVL_HIGH   = 2'd2;
  localparam logic [LVL_W-1:0] LVL_CRIT   = 2'd3;

  localparam logic [WGT_W-1:0] WGT_LOW    = 7'd1;
  localparam logic [WGT_W-1:0] WGT_MEDIUM = 7'd5;
  localparam logic [WGT_W-1:0] WGT_HIGH   = 7'd25;
  localparam logic [WGT_W-1:0] WGT_CRIT   = 7'd100;

  // stream payload layout
  localparam int IN_TIME_LSB = 0;
  localparam int IN_SEV_LSB  = IN_TIME_LSB + TIME_BITS;
  localparam int IN_NOW_LSB  = IN_SEV_LSB + SEV_W;
  localparam int IN_BITS     = IN_NOW_LSB + TIME_BITS;
  localparam int IN_DATA_W   = ((IN_BITS + 7) / 8) * 8;

  localparam int OUT_BITS   = 2 * LVL_W + 3;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  typedef struct packed {
    logic [TIME_BITS-1:0] time_ms;
    logic [SEV_W-1:0]     severity;
  } entry_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    entry_t            data;
  } mem_wr_t;

  typedef struct packed {
    logic [WIN_W-1:0]  window_ms;
    logic [HOLD_W-1:0] promote_hold_ms;
    logic [HOLD_W-1:0] demote_hold_ms;
    logic [THR_W-1:0]  critical_threshold;
    logic [THR_W-1:0]  high_threshold;
    logic [THR_W-1:0]  medium_threshold;
  } cfg_t;

  typedef struct packed {
    logic [LVL_W-1:0] displayed_level;
    logic [LVL_W-1:0] raw_level;
    logic             level_changed;
    logic             was_promoted;
  } level_res_t;

  function automatic logic [WGT_W-1:0] sev_weight(input logic [SEV_W-1:0] sev);
    logic [WGT_W-1:0] w;
    unique case (sev)
      SEV_LOW:    w = WGT_LOW;
      SEV_MEDIUM: w = WGT_MEDIUM;
      SEV_HIGH:   w = WGT_HIGH;
      SEV_CRIT:   w = WGT_CRIT;
      default:    w = WGT_LOW;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/delm_event_store.sv =====
// Event memory: one write port, one read port with registered read data.
// Depends on delm_pkg.
`default_nettype none

module delm_event_store (
  input  logic                     clk,
  input  delm_pkg::mem_wr_t        wr,
  input  logic                     rd_en,
  input  logic [delm_pkg::ADDR_W-1:0] rd_addr,
  output delm_pkg::entry_t         rd_data
);

  delm_pkg::entry_t mem [delm_pkg::EVENT_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/delm_walk.sv =====
// Tick walk over the event memory: prune, compact in place and accumulate the
// decayed score through a read, age, multiply and add pipeline. Depends on delm_pkg.
`default_nettype none

module delm_walk (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [delm_pkg::TIME_BITS-1:0] now_ms,
  input  logic [delm_pkg::WIN_W-1:0]    window_ms,
  input  logic [delm_pkg::CNT_W-1:0]    count,
  output logic                          rd_en,
  output logic [delm_pkg::ADDR_W-1:0]   rd_addr,
  input  delm_pkg::entry_t              rd_data,
  output delm_pkg::mem_wr_t             wr,
  output logic                          done,
  output logic [delm_pkg::CNT_W-1:0]    kept,
  output logic [delm_pkg::SUM_W-1:0]    sum
);

  logic                          busy;
  logic [delm_pkg::CNT_W-1:0]    rd_idx;
  logic                          rv;
  logic                          s1_valid;
  logic [delm_pkg::WIN_W-1:0]    s1_diff;
  logic [delm_pkg::WGT_W-1:0]    s1_wgt;
  logic                          s2_valid;
  logic [delm_pkg::PROD_W-1:0]   s2_prod;

  logic                          future;
  logic [delm_pkg::TIME_BITS-1:0] age;
  logic                          in_win;
  logic                          keep;

  always_comb begin
    future  = rd_data.time_ms > now_ms;
    age     = now_ms - rd_data.time_ms;
    in_win  = !future && (age <= delm_pkg::TIME_BITS'(window_ms));
    keep    = future || in_win;
    rd_en   = busy && (rd_idx < count);
    rd_addr = rd_idx[delm_pkg::ADDR_W-1:0];
    wr.en   = rv && keep;
    wr.addr = kept[delm_pkg::ADDR_W-1:0];
    wr.data = rd_data;
    done    = busy && !rd_en && !rv && !s1_valid && !s2_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      rd_idx   <= '0;
      rv       <= 1'b0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      kept     <= '0;
      sum      <= '0;
    end else if (start) begin
      busy     <= 1'b1;
      rd_idx   <= '0;
      rv       <= 1'b0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      kept     <= '0;
      sum      <= '0;
    end else begin
      if (rd_en) begin
        rd_idx <= rd_idx + 1'b1;
      end
      rv       <= rd_en;
      s1_valid <= rv && in_win;
      s2_valid <= s1_valid;
      if (wr.en) begin
        kept <= kept + 1'b1;
      end
      if (s2_valid) begin
        sum <= sum + delm_pkg::SUM_W'(s2_prod);
      end
      if (done) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_diff <= window_ms - age[delm_pkg::WIN_W-1:0];
    s1_wgt  <= delm_pkg::sev_weight(rd_data.severity);
    s2_prod <= delm_pkg::PROD_W'(s1_wgt) * delm_pkg::PROD_W'(s1_diff);
  end

endmodule

`default_nettype wire

// ===== hw/rtl/delm_level_hold.sv =====
// Threshold compare of the decayed score and the promote/demote hold filter.
// Depends on delm_pkg.
`default_nettype none

module delm_level_hold (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [delm_pkg::SUM_W-1:0]    sum,
  input  logic [delm_pkg::TIME_BITS-1:0] now_ms,
  input  delm_pkg::cfg_t                cfg,
  output logic                          done,
  output delm_pkg::level_res_t          res
);

  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_CRIT   = 3'd1;
  localparam logic [2:0] PH_HIGH   = 3'd2;
  localparam logic [2:0] PH_MED    = 3'd3;
  localparam logic [2:0] PH_LAST   = 3'd4;
  localparam logic [2:0] PH_DECIDE = 3'd5;

  logic [2:0]                     phase;
  logic [delm_pkg::THRP_W-1:0]    thr_prod;
  logic [delm_pkg::THR_W-1:0]     thr_sel;
  logic                           hit_now;
  logic                           hit_crit;
  logic                           hit_high;
  logic                           hit_med;

  logic [delm_pkg::LVL_W-1:0]     shown_level;
  logic                           rise_armed;
  logic [delm_pkg::TIME_BITS-1:0] rise_start_ms;
  logic                           fall_armed;
  logic [delm_pkg::TIME_BITS-1:0] fall_start_ms;

  logic [delm_pkg::LVL_W-1:0]     raw;
  logic [delm_pkg::TIME_BITS-1:0] rise_from;
  logic [delm_pkg::TIME_BITS-1:0] fall_from;
  logic                           rise_done;
  logic                           fall_done;

  always_comb begin
    unique case (phase)
      PH_CRIT: thr_sel = cfg.critical_threshold;
      PH_HIGH: thr_sel = cfg.high_threshold;
      default: thr_sel = cfg.medium_threshold;
    endcase
    hit_now = delm_pkg::CMP_W'(sum) >= delm_pkg::CMP_W'(thr_prod);

    priority if (hit_crit) begin
      raw = delm_pkg::LVL_CRIT;
    end else if (hit_high) begin
      raw = delm_pkg::LVL_HIGH;
    end else if (hit_med) begin
      raw = delm_pkg::LVL_MEDIUM;
    end else begin
      raw = delm_pkg::LVL_LOW;
    end

    rise_from = rise_armed ? rise_start_ms : now_ms;
    fall_from = fall_armed ? fall_start_ms : now_ms;
    rise_done = (now_ms >= rise_from) &&
                ((now_ms - rise_from) >= delm_pkg::TIME_BITS'(cfg.promote_hold_ms));
    fall_done = (now_ms >= fall_from) &&
                ((now_ms - fall_from) >= delm_pkg::TIME_BITS'(cfg.demote_hold_ms));
    done = (phase == PH_DECIDE);
  end

  always_ff @(posedge clk) begin
    thr_prod <= delm_pkg::THRP_W'(thr_sel) * delm_pkg::THRP_W'(cfg.window_ms);
    unique case (phase)
      PH_HIGH: hit_crit <= hit_now;
      PH_MED:  hit_high <= hit_now;
      PH_LAST: hit_med  <= hit_now;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      shown_level   <= delm_pkg::LVL_LOW;
      rise_armed    <= 1'b0;
      rise_start_ms <= '0;
      fall_armed    <= 1'b0;
      fall_start_ms <= '0;
      res           <= '0;
    end else begin
      unique case (phase)
        PH_IDLE: begin
          if (start) begin
            phase <= PH_CRIT;
          end
        end
        PH_CRIT:  phase <= PH_HIGH;
        PH_HIGH:  phase <= PH_MED;
        PH_MED:   phase <= PH_LAST;
        PH_LAST:  phase <= PH_DECIDE;
        PH_DECIDE: begin
          phase               <= PH_IDLE;
          res.raw_level       <= raw;
          res.level_changed   <= 1'b0;
          res.was_promoted    <= 1'b0;
          res.displayed_level <= shown_level;
          if (raw > shown_level) begin
            fall_armed    <= 1'b0;
            fall_start_ms <= '0;
            if (rise_done) begin
              shown_level         <= raw;
              res.displayed_level <= raw;
              res.level_changed   <= 1'b1;
              res.was_promoted    <= 1'b1;
              rise_armed          <= 1'b0;
              rise_start_ms       <= '0;
            end else begin
              rise_armed    <= 1'b1;
              rise_start_ms <= rise_from;
            end
          end else if (raw < shown_level) begin
            rise_armed    <= 1'b0;
            rise_start_ms <= '0;
            if (fall_done) begin
              shown_level         <= raw;
              res.displayed_level <= raw;
              res.level_changed   <= 1'b1;
              fall_armed          <= 1'b0;
              fall_start_ms       <= '0;
            end else begin
              fall_armed    <= 1'b1;
              fall_start_ms <= fall_from;
            end
          end else begin
            rise_armed    <= 1'b0;
            rise_start_ms <= '0;
            fall_armed    <= 1'b0;
            fall_start_ms <= '0;
          end
        end
        default: phase <= PH_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/decayed_event_level_monitor_top.sv =====
// Decayed event level monitor: a store item (tuser 0) writes the event into the
// event memory, or flags a drop when the memory is full. A tick (tuser 1) walks
// every stored event once through the single read port of the event memory
// before its result is offered; one item is worked on at a time. Results wait
// in an output register, and a new item is accepted while one is still pending.
// Configuration writes take effect at the clock edge where cfg_wen is high.
// Depends on delm_pkg, delm_event_store, delm_walk and delm_level_hold.
`default_nettype none

module decayed_event_level_monitor_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // event_time_ms[47:0], event_severity[49:48], now_ms[97:50], zero fill
  input  logic [delm_pkg::IN_DATA_W-1:0]    s_tdata,
  // func
  input  logic                              s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // displayed_level[1:0], raw_level[3:2], level_changed[4], was_promoted[5],
  // events_dropped[6], zero fill
  output logic [delm_pkg::OUT_DATA_W-1:0]   m_tdata,
  input  logic                              cfg_wen,
  input  logic [delm_pkg::CFG_ADDR_W-1:0]   cfg_index,
  input  logic [delm_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_WALK  = 2'd1;
  localparam logic [1:0] ST_LEVEL = 2'd2;
  localparam logic [1:0] ST_OUT   = 2'd3;

  logic [1:0]                      state;
  delm_pkg::cfg_t                  cfg;
  logic [delm_pkg::CNT_W-1:0]      event_count;
  logic                            drop_seen;
  logic [delm_pkg::TIME_BITS-1:0]  now_r;

  logic                            accept;
  logic                            accept_store;
  logic                            accept_tick;
  logic                            store_room;
  logic                            out_free;
  logic                            out_load;

  delm_pkg::mem_wr_t               store_wr;
  delm_pkg::mem_wr_t               walk_wr;
  delm_pkg::mem_wr_t               mem_wr;
  logic                            rd_en;
  logic [delm_pkg::ADDR_W-1:0]     rd_addr;
  delm_pkg::entry_t                rd_data;

  logic                            walk_done;
  logic [delm_pkg::CNT_W-1:0]      walk_kept;
  logic [delm_pkg::SUM_W-1:0]      walk_sum;
  logic                            level_done;
  delm_pkg::level_res_t            level_res;

  always_comb begin
    s_tready     = (state == ST_IDLE);
    accept       = s_tvalid && s_tready;
    accept_store = accept && (s_tuser == delm_pkg::FUNC_STORE);
    accept_tick  = accept && (s_tuser == delm_pkg::FUNC_TICK);
    store_room   = event_count < delm_pkg::CNT_W'(delm_pkg::EVENT_DEPTH);
    out_free     = !m_tvalid || m_tready;
    out_load     = (state == ST_OUT) && out_free;

    store_wr.en            = accept_store && store_room;
    store_wr.addr          = event_count[delm_pkg::ADDR_W-1:0];
    store_wr.data.time_ms  = s_tdata[delm_pkg::IN_TIME_LSB +: delm_pkg::TIME_BITS];
    store_wr.data.severity = s_tdata[delm_pkg::IN_SEV_LSB +: delm_pkg::SEV_W];
    mem_wr = (state == ST_IDLE) ? store_wr : walk_wr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.window_ms          <= delm_pkg::WINDOW_RST;
      cfg.promote_hold_ms    <= delm_pkg::PROMOTE_RST;
      cfg.demote_hold_ms     <= delm_pkg::DEMOTE_RST;
      cfg.critical_threshold <= delm_pkg::CRIT_THR_RST;
      cfg.high_threshold     <= delm_pkg::HIGH_THR_RST;
      cfg.medium_threshold   <= delm_pkg::MED_THR_RST;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        delm_pkg::REG_WINDOW:   cfg.window_ms          <= cfg_data[delm_pkg::WIN_W-1:0];
        delm_pkg::REG_PROMOTE:  cfg.promote_hold_ms    <= cfg_data[delm_pkg::HOLD_W-1:0];
        delm_pkg::REG_DEMOTE:   cfg.demote_hold_ms     <= cfg_data[delm_pkg::HOLD_W-1:0];
        delm_pkg::REG_CRIT_THR: cfg.critical_threshold <= cfg_data[delm_pkg::THR_W-1:0];
        delm_pkg::REG_HIGH_THR: cfg.high_threshold     <= cfg_data[delm_pkg::THR_W-1:0];
        delm_pkg::REG_MED_THR:  cfg.medium_threshold   <= cfg_data[delm_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept_tick) begin
      now_r <= s_tdata[delm_pkg::IN_NOW_LSB +: delm_pkg::TIME_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      event_count <= '0;
      drop_seen   <= 1'b0;
      m_tvalid    <= 1'b0;
      m_tdata     <= '0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (store_wr.en) begin
            event_count <= event_count + 1'b1;
          end
          if (accept_store && !store_room) begin
            drop_seen <= 1'b1;
          end
          if (accept_tick) begin
            state <= ST_WALK;
          end
        end
        ST_WALK: begin
          if (walk_done) begin
            event_count <= walk_kept;
            state       <= ST_LEVEL;
          end
        end
        ST_LEVEL: begin
          if (level_done) begin
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            m_tdata   <= delm_pkg::OUT_DATA_W'({drop_seen,
                                                level_res.was_promoted,
                                                level_res.level_changed,
                                                level_res.raw_level,
                                                level_res.displayed_level});
            drop_seen <= 1'b0;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  delm_event_store u_store (
    .clk     (clk),
    .wr      (mem_wr),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  delm_walk u_walk (
    .clk       (clk),
    .rst       (rst),
    .start     (accept_tick),
    .now_ms    (now_r),
    .window_ms (cfg.window_ms),
    .count     (event_count),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .wr        (walk_wr),
    .done      (walk_done),
    .kept      (walk_kept),
    .sum       (walk_sum)
  );

  delm_level_hold u_level (
    .clk    (clk),
    .rst    (rst),
    .start  ((state == ST_WALK) && walk_done),
    .sum    (walk_sum),
    .now_ms (now_r),
    .cfg    (cfg),
    .done   (level_done),
    .res    (level_res)
  );

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// Testbench for decayed_event_level_monitor_top: sends store and tick transactions,
// models the event store, scoring and hold logic, and checks every level report.
// Depends on delm_pkg and the RTL under hw/rtl.
`default_nettype none

module tb;

  localparam logic [delm_pkg::CFG_ADDR_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [delm_pkg::CFG_ADDR_W-1:0] REG_SPARE_B = 3'd7;
  localparam logic [63:0] TIME_MAX = (64'd1 << delm_pkg::TIME_BITS) - 64'd1;
  localparam int SETTLE_CYCLES = 32;

  typedef struct packed {
    logic [delm_pkg::LVL_W-1:0] shown;
    logic [delm_pkg::LVL_W-1:0] raw;
    logic                       changed;
    logic                       promoted;
    logic                       dropped;
  } level_report_t;

  logic                            clk = 1'b0;
  logic                            rst;
  logic                            s_tvalid;
  logic                            s_tready;
  logic [delm_pkg::IN_DATA_W-1:0]  s_tdata;
  logic                            s_tuser;
  logic                            m_tvalid;
  logic                            m_tready;
  logic [delm_pkg::OUT_DATA_W-1:0] m_tdata;
  logic                            cfg_wen;
  logic [delm_pkg::CFG_ADDR_W-1:0] cfg_index;
  logic [delm_pkg::CFG_DATA_W-1:0] cfg_data;

  // event store and hold state of the level model
  logic [delm_pkg::TIME_BITS-1:0] ev_time [delm_pkg::EVENT_DEPTH];
  logic [delm_pkg::SEV_W-1:0]     ev_sev [delm_pkg::EVENT_DEPTH];
  int                             ev_fill;
  logic [delm_pkg::LVL_W-1:0]     shown_lvl;
  logic                           rise_pending;
  logic [63:0]                    rise_since;
  logic                           fall_pending;
  logic [63:0]                    fall_since;
  logic                           drop_flag;
  logic [63:0]                    sev_points [4];

  logic [63:0] win, up_hold, down_hold, thr_crit, thr_high, thr_med;

  level_report_t pending_reports[$];
  int            mismatches;
  int            stall_left;
  bit            idle_on;
  logic [63:0]   clock_ms;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  decayed_event_level_monitor_top u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_wen  (cfg_wen),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  function automatic void reset_model();
    ev_fill      = 0;
    shown_lvl    = delm_pkg::LVL_LOW;
    rise_pending = 1'b0;
    rise_since   = '0;
    fall_pending = 1'b0;
    fall_since   = '0;
    drop_flag    = 1'b0;
    sev_points[delm_pkg::SEV_LOW]    = 64'(delm_pkg::WGT_LOW);
    sev_points[delm_pkg::SEV_MEDIUM] = 64'(delm_pkg::WGT_MEDIUM);
    sev_points[delm_pkg::SEV_HIGH]   = 64'(delm_pkg::WGT_HIGH);
    sev_points[delm_pkg::SEV_CRIT]   = 64'(delm_pkg::WGT_CRIT);
    win       = 64'(delm_pkg::WINDOW_RST);
    up_hold   = 64'(delm_pkg::PROMOTE_RST);
    down_hold = 64'(delm_pkg::DEMOTE_RST);
    thr_crit  = 64'(delm_pkg::CRIT_THR_RST);
    thr_high  = 64'(delm_pkg::HIGH_THR_RST);
    thr_med   = 64'(delm_pkg::MED_THR_RST);
  endfunction

  function automatic void record_event(input logic [63:0] t_ms,
                                       input logic [delm_pkg::SEV_W-1:0] sev);
    if (ev_fill < delm_pkg::EVENT_DEPTH) begin
      ev_time[ev_fill] = t_ms[delm_pkg::TIME_BITS-1:0];
      ev_sev[ev_fill]  = sev;
      ev_fill++;
    end else begin
      drop_flag = 1'b1;
    end
  endfunction

  function automatic level_report_t predict_tick(input logic [63:0] now);
    logic [63:0]                sum;
    logic [63:0]                age;
    int                         kept;
    logic [delm_pkg::LVL_W-1:0] raw;
    level_report_t              rep;
    sum  = '0;
    kept = 0;
    rep  = '0;
    for (int i = 0; i < ev_fill; i++) begin
      if (64'(ev_time[i]) > now) begin
        ev_time[kept] = ev_time[i];
        ev_sev[kept]  = ev_sev[i];
        kept++;
      end else begin
        age = now - 64'(ev_time[i]);
        if (age <= win) begin
          sum += sev_points[ev_sev[i]] * (win - age);
          ev_time[kept] = ev_time[i];
          ev_sev[kept]  = ev_sev[i];
          kept++;
        end
      end
    end
    ev_fill = kept;

    if (sum >= thr_crit * win) raw = delm_pkg::LVL_CRIT;
    else if (sum >= thr_high * win) raw = delm_pkg::LVL_HIGH;
    else if (sum >= thr_med * win) raw = delm_pkg::LVL_MEDIUM;
    else raw = delm_pkg::LVL_LOW;

    if (raw > shown_lvl) begin
      if (!rise_pending) begin
        rise_pending = 1'b1;
        rise_since   = now;
      end
      fall_pending = 1'b0;
      fall_since   = '0;
      if (now >= rise_since && now - rise_since >= up_hold) begin
        shown_lvl    = raw;
        rise_pending = 1'b0;
        rise_since   = '0;
        rep.changed  = 1'b1;
        rep.promoted = 1'b1;
      end
    end else if (raw < shown_lvl) begin
      if (!fall_pending) begin
        fall_pending = 1'b1;
        fall_since   = now;
      end
      rise_pending = 1'b0;
      rise_since   = '0;
      if (now >= fall_since && now - fall_since >= down_hold) begin
        shown_lvl    = raw;
        fall_pending = 1'b0;
        fall_since   = '0;
        rep.changed  = 1'b1;
      end
    end else begin
      rise_pending = 1'b0;
      rise_since   = '0;
      fall_pending = 1'b0;
      fall_since   = '0;
    end

    rep.shown   = shown_lvl;
    rep.raw     = raw;
    rep.dropped = drop_flag;
    drop_flag   = 1'b0;
    return rep;
  endfunction

  function automatic logic [63:0] rand_below(input logic [63:0] n);
    return {$urandom, $urandom} % n;
  endfunction

  function automatic logic [63:0] rand48();
    return {$urandom, $urandom} & TIME_MAX;
  endfunction

  function automatic logic [delm_pkg::SEV_W-1:0] rand_sev();
    return delm_pkg::SEV_W'($urandom_range(0, 3));
  endfunction

  function automatic logic [delm_pkg::CFG_DATA_W-1:0] rand_cfg(input int unsigned lo,
                                                              input int unsigned hi);
    return delm_pkg::CFG_DATA_W'($urandom_range(lo, hi));
  endfunction

  function automatic void note_mismatch(input string what, input level_report_t want,
                                        input level_report_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t %s: expected shown=%0d raw=%0d changed=%0b promoted=%0b dropped=%0b",
               $time, what, want.shown, want.raw, want.changed, want.promoted, want.dropped);
      $display("%0t %s: actual   shown=%0d raw=%0d changed=%0b promoted=%0b dropped=%0b",
               $time, what, got.shown, got.raw, got.changed, got.promoted, got.dropped);
    end
  endfunction

  always @(posedge clk) begin : check_reports
    level_report_t want;
    level_report_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.shown    = m_tdata[1:0];
      got.raw      = m_tdata[3:2];
      got.changed  = m_tdata[4];
      got.promoted = m_tdata[5];
      got.dropped  = m_tdata[6];
      if (pending_reports.size() == 0) begin
        note_mismatch("report with no tick pending", '0, got);
      end else begin
        want = pending_reports.pop_front();
        if (want !== got) note_mismatch("report mismatch", want, got);
      end
    end
    if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 10);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  task automatic send_item(input logic func, input logic [63:0] t_ms,
                           input logic [delm_pkg::SEV_W-1:0] sev, input logic [63:0] now_ms);
    int                             gap;
    logic [delm_pkg::IN_DATA_W-1:0] word;
    gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 11) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    word = '0;
    word[delm_pkg::IN_TIME_LSB +: delm_pkg::TIME_BITS] = t_ms[delm_pkg::TIME_BITS-1:0];
    word[delm_pkg::IN_SEV_LSB +: delm_pkg::SEV_W]      = sev;
    word[delm_pkg::IN_NOW_LSB +: delm_pkg::TIME_BITS]  = now_ms[delm_pkg::TIME_BITS-1:0];
    s_tvalid <= 1'b1;
    s_tdata  <= word;
    s_tuser  <= func;
    do @(posedge clk); while (!s_tready);
    if (func == delm_pkg::FUNC_TICK) begin
      pending_reports.insert(pending_reports.size(), predict_tick(now_ms & TIME_MAX));
    end else begin
      record_event(t_ms & TIME_MAX, sev);
    end
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [delm_pkg::CFG_ADDR_W-1:0] idx,
                           input logic [delm_pkg::CFG_DATA_W-1:0] val);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      delm_pkg::REG_WINDOW:   win       = 64'(val);
      delm_pkg::REG_PROMOTE:  up_hold   = 64'(val);
      delm_pkg::REG_DEMOTE:   down_hold = 64'(val);
      delm_pkg::REG_CRIT_THR: thr_crit  = 64'(val[delm_pkg::THR_W-1:0]);
      delm_pkg::REG_HIGH_THR: thr_high  = 64'(val[delm_pkg::THR_W-1:0]);
      delm_pkg::REG_MED_THR:  thr_med   = 64'(val[delm_pkg::THR_W-1:0]);
      default: ;
    endcase
  endtask

  task automatic program_config(input logic [delm_pkg::CFG_DATA_W-1:0] w, prom, dem, crit,
                                high, med);
    write_reg(delm_pkg::REG_WINDOW, w);
    write_reg(delm_pkg::REG_PROMOTE, prom);
    write_reg(delm_pkg::REG_DEMOTE, dem);
    write_reg(delm_pkg::REG_CRIT_THR, crit);
    write_reg(delm_pkg::REG_HIGH_THR, high);
    write_reg(delm_pkg::REG_MED_THR, med);
    write_reg(REG_SPARE_A, delm_pkg::CFG_DATA_W'($urandom));
    write_reg(REG_SPARE_B, delm_pkg::CFG_DATA_W'($urandom));
    cfg_wen <= 1'b0;
  endtask

  task automatic program_defaults();
    program_config(delm_pkg::WINDOW_RST, delm_pkg::PROMOTE_RST, delm_pkg::DEMOTE_RST,
                   delm_pkg::CFG_DATA_W'(delm_pkg::CRIT_THR_RST),
                   delm_pkg::CFG_DATA_W'(delm_pkg::HIGH_THR_RST),
                   delm_pkg::CFG_DATA_W'(delm_pkg::MED_THR_RST));
  endtask

  task automatic random_traffic(input int count, input int store_pct, input bit crawl);
    logic [63:0] span;
    logic [63:0] pace;
    logic [63:0] t_ms;
    logic [63:0] now_ms;
    int          roll;
    for (int n = 0; n < count; n++) begin
      span = (win == 0) ? 64'd1 : win;
      pace = ((up_hold > down_hold) ? up_hold : down_hold) / 2 + span / 16 + 1;
      if (!crawl && $urandom_range(0, 199) == 0) wait_drained();
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
        send_item(1'($urandom_range(0, 1)), rand48(), rand_sev(), rand48());
      end else if (roll < 3 + store_pct) begin
        t_ms = clock_ms - rand_below(span + span / 4 + 1);
        if ($urandom_range(0, 7) == 0) t_ms = clock_ms + rand_below(span / 4 + 2);
        send_item(delm_pkg::FUNC_STORE, t_ms & TIME_MAX, rand_sev(), rand48());
      end else begin
        roll = $urandom_range(0, 99);
        if (crawl) clock_ms += rand_below(1000);
        else if (roll < 70) clock_ms += rand_below(pace);
        else if (roll < 85) clock_ms += rand_below(span);
        else if (roll < 90) clock_ms += span + rand_below(64'h400_0000);
        clock_ms &= TIME_MAX;
        now_ms = (roll >= 90) ? (clock_ms - rand_below(span / 8 + 2)) & TIME_MAX : clock_ms;
        send_item(delm_pkg::FUNC_TICK, rand48(), rand_sev(), now_ms);
      end
    end
  endtask

  task automatic test_directed_cases();
    send_item(delm_pkg::FUNC_TICK, '0, delm_pkg::SEV_LOW, 64'd0);
    send_item(delm_pkg::FUNC_STORE, 64'd0, delm_pkg::SEV_CRIT, TIME_MAX);
    send_item(delm_pkg::FUNC_STORE, 64'd0, delm_pkg::SEV_HIGH, '0);
    send_item(delm_pkg::FUNC_STORE, 64'd0, delm_pkg::SEV_MEDIUM, '0);
    send_item(delm_pkg::FUNC_STORE, 64'd0, delm_pkg::SEV_LOW, '0);
    send_item(delm_pkg::FUNC_TICK, TIME_MAX, delm_pkg::SEV_CRIT, 64'd0);
    send_item(delm_pkg::FUNC_TICK, '0, delm_pkg::SEV_LOW, 64'd10000);
    send_item(delm_pkg::FUNC_TICK, '0, delm_pkg::SEV_LOW, 64'd5000);
    send_item(delm_pkg::FUNC_STORE, TIME_MAX, delm_pkg::SEV_CRIT, '0);
    send_item(delm_pkg::FUNC_TICK, '0, delm_pkg::SEV_LOW, 64'd900000);
    send_item(delm_pkg::FUNC_TICK, '0, delm_pkg::SEV_LOW, 64'd900001);
    send_item(delm_pkg::FUNC_TICK, '0, delm_pkg::SEV_LOW, 64'd900000);
    send_item(delm_pkg::FUNC_TICK, '0, delm_pkg::SEV_LOW, 64'd960001);
    send_item(delm_pkg::FUNC_TICK, '0, delm_pkg::SEV_LOW, TIME_MAX);
    send_item(delm_pkg::FUNC_TICK, '0, delm_pkg::SEV_LOW, TIME_MAX);
    send_item(delm_pkg::FUNC_STORE, TIME_MAX - 5, delm_pkg::SEV_HIGH, '0);
    send_item(delm_pkg::FUNC_TICK, '0, delm_pkg::SEV_LOW, TIME_MAX);
    send_item(delm_pkg::FUNC_TICK, '0, delm_pkg::SEV_LOW, TIME_MAX - 20000);
  endtask

  task automatic test_reset_settings();
    wait_drained();
    program_defaults();
    clock_ms = 64'd1_000_000;
    random_traffic(300, 50, 1'b0);
  endtask

  task automatic test_short_window();
    wait_drained();
    program_config(rand_cfg(1, 2000), rand_cfg(0, 3000), rand_cfg(0, 3000),
                   delm_pkg::CFG_DATA_W'(delm_pkg::CRIT_THR_RST),
                   delm_pkg::CFG_DATA_W'(delm_pkg::HIGH_THR_RST),
                   delm_pkg::CFG_DATA_W'(delm_pkg::MED_THR_RST));
    random_traffic(300, 55, 1'b0);
  endtask

  task automatic test_store_overflow();
    wait_drained();
    program_config(24'hFFFFFF, rand_cfg(0, 2000), rand_cfg(0, 2000), 24'd20000, 24'd3000,
                   24'd300);
    random_traffic(400, 88, 1'b1);
  endtask

  task automatic test_extreme_settings();
    wait_drained();
    program_config(24'd1, 24'd0, 24'd0, 24'd1, 24'd1, 24'd1);
    clock_ms = TIME_MAX - rand_below(20000);
    random_traffic(150, 50, 1'b0);
    wait_drained();
    program_config(24'd0, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'h000000, 24'hFF0000);
    random_traffic(150, 50, 1'b0);
    send_item(delm_pkg::FUNC_TICK, rand48(), delm_pkg::SEV_LOW, TIME_MAX);
    clock_ms = 64'd5_000_000;
  endtask

  task automatic test_mixed_settings();
    for (int k = 0; k < 3; k++) begin
      wait_drained();
      case (k)
        0: program_config(rand_cfg(1, 50000), rand_cfg(0, 20000), rand_cfg(0, 20000),
                          rand_cfg(60, 150), rand_cfg(20, 59), rand_cfg(1, 19));
        1: program_config(rand_cfg(1, 24'hFFFFFF), rand_cfg(0, 24'hFFFFFF),
                          rand_cfg(0, 24'hFFFFFF), rand_cfg(0, 200),
                          rand_cfg(0, 200), rand_cfg(0, 200));
        default: program_config(rand_cfg(1, 100), rand_cfg(0, 100), rand_cfg(0, 100),
                                delm_pkg::CFG_DATA_W'(delm_pkg::CRIT_THR_RST),
                                delm_pkg::CFG_DATA_W'(delm_pkg::HIGH_THR_RST),
                                delm_pkg::CFG_DATA_W'(delm_pkg::MED_THR_RST));
      endcase
      random_traffic(100, 50, 1'b0);
    end
  endtask

  task automatic test_steady_stream();
    wait_drained();
    idle_on = 1'b0;
    program_defaults();
    random_traffic(250, 50, 1'b0);
  endtask

  initial begin
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= delm_pkg::FUNC_STORE;
    m_tready  <= 1'b0;
    cfg_wen   <= 1'b0;
    cfg_index <= delm_pkg::REG_WINDOW;
    cfg_data  <= '0;
    reset_model();
    mismatches = 0;
    stall_left = 0;
    idle_on    = 1'b1;
    clock_ms   = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_directed_cases();
    test_reset_settings();
    test_short_window();
    test_store_overflow();
    test_extreme_settings();
    test_mixed_settings();
    test_steady_stream();
    wait_drained();

    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

`default_nettype wire
